FILE: rtl/ftaq_pkg.sv
// ----------------------------------------------------------------------------
// ftaq_pkg: shared types and constants for the frame-time quality controller
// Widths, register indexes, adjustment codes, Q1.15 constants and the
// fixed-point scaling helpers used by the quality stage.
// ----------------------------------------------------------------------------
package ftaq_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 120;

   localparam int FRAME_W     = 32;
   localparam int TARGET_W    = 30;
   localparam int LEVEL_W     = 16;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 30;

   // Dividend bits retired by one divider cell.
   localparam int STEP_BITS = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADAPTIVE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DYN_RES  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RAISE = 2'd2;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 30'd16666667;

   localparam logic [LEVEL_W-1:0] Q_ONE  = 16'd32768;
   localparam logic [LEVEL_W-1:0] Q_HALF = 16'd16384;
   // Floors of the effect and resolution factors, held as ten times the factor.
   localparam logic [19:0] EFFECT_FLOOR_X10 = 20'd98304;
   localparam logic [19:0] RES_FLOOR_X10    = 20'd229376;

   // floor(x / 100) equals (x * ceil(2^29 / 100)) >> 29 for every x below 2^22,
   // which covers every factor times its percentage.
   localparam int SCALE_SHIFT = 29;
   localparam int SCALE_MUL_W = 30;
   localparam int RECIP_100   = 5368710;
   localparam logic [SCALE_MUL_W-1:0] MUL_95  = SCALE_MUL_W'(95 * RECIP_100);
   localparam logic [SCALE_MUL_W-1:0] MUL_98  = SCALE_MUL_W'(98 * RECIP_100);
   localparam logic [SCALE_MUL_W-1:0] MUL_101 = SCALE_MUL_W'(101 * RECIP_100);
   localparam logic [SCALE_MUL_W-1:0] MUL_102 = SCALE_MUL_W'(102 * RECIP_100);

   typedef struct packed {
      logic [FRAME_W-1:0] frame_ns;
   } req_payload_type;

   typedef struct packed {
      logic [FRAME_W-1:0] avg_frame_ns;
      logic [LEVEL_W-1:0] texture_level;
      logic [LEVEL_W-1:0] effect_level;
      logic [LEVEL_W-1:0] resolution_level;
      logic [KIND_W-1:0]  adjust_kind;
   } rsp_payload_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target_frame_ns;
      logic                adaptive_enable;
      logic                dynamic_resolution_enable;
   } cfg_type;

   function automatic int rem_width(input int depth);
      return $clog2(depth) + 1;
   endfunction

   function automatic int div_width(input int depth);
      int sum_w;
      sum_w = FRAME_W + $clog2(depth);
      return ((sum_w + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
   endfunction

   // Floored factor times a percentage, as a 17-bit value.
   function automatic logic [LEVEL_W:0] scale_q15(input logic [LEVEL_W-1:0] f,
                                                  input logic [SCALE_MUL_W-1:0] mul);
      logic [LEVEL_W+SCALE_MUL_W-1:0] prod;
      prod = {{SCALE_MUL_W{1'b0}}, f} * {{LEVEL_W{1'b0}}, mul};
      return prod[SCALE_SHIFT+LEVEL_W:SCALE_SHIFT];
   endfunction

   function automatic logic [LEVEL_W-1:0] clamp_q15(input logic [LEVEL_W:0] v);
      return (v > {1'b0, Q_ONE}) ? Q_ONE : v[LEVEL_W-1:0];
   endfunction

endpackage

FILE: rtl/ftaq_if.sv
// ----------------------------------------------------------------------------
// ftaq_if: valid/ready channels of the frame-time quality controller
// One interface for frame-time requests and one for quality responses.
// ----------------------------------------------------------------------------
interface ftaq_req_if;
   import ftaq_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ftaq_rsp_if;
   import ftaq_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/ftaq_hist_cell.sv
// ----------------------------------------------------------------------------
// ftaq_hist_cell: one entry of the frame-time history line
// Holds one frame time and passes it to the next cell on every accepted frame.
// ----------------------------------------------------------------------------
module ftaq_hist_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [ftaq_pkg::FRAME_W-1:0]  data_in,
   output logic [ftaq_pkg::FRAME_W-1:0]  data_out
);
   import ftaq_pkg::*;

   logic [FRAME_W-1:0] data_ff;
   logic [FRAME_W-1:0] data_in_sel;

   assign data_in_sel = shift_en ? data_in : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in_sel;
      end
   end

   assign data_out = data_ff;

endmodule

FILE: rtl/ftaq_div_cell.sv
// ----------------------------------------------------------------------------
// ftaq_div_cell: one cell of the averaging divider chain
// Retires a few dividend bits by restoring division by the history depth and
// hands the partial remainder and the shifted word to the next cell.
// ----------------------------------------------------------------------------
module ftaq_div_cell #(
   parameter int  HISTORY_DEPTH = ftaq_pkg::HISTORY_DEPTH_DEFAULT,
   localparam int REM_W = ftaq_pkg::rem_width(HISTORY_DEPTH),
   localparam int DIV_W = ftaq_pkg::div_width(HISTORY_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  logic [REM_W-1:0] rem_in,
   input  logic [DIV_W-1:0] word_in,
   output logic             down_valid,
   input  logic             down_ready,
   output logic [REM_W-1:0] rem_out,
   output logic [DIV_W-1:0] word_out
);
   import ftaq_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_next;
   logic [DIV_W-1:0] word_ff;
   logic [DIV_W-1:0] word_next;
   logic             load;

   // The word shifts the dividend out at the top and the quotient in at the
   // bottom, so after the last cell it holds the quotient alone.
   always_comb begin
      logic [REM_W-1:0] r;
      logic [DIV_W-1:0] w;
      r = rem_in;
      w = word_in;
      for (int b = 0; b < STEP_BITS; b++) begin
         r = {r[REM_W-2:0], w[DIV_W-1]};
         w = {w[DIV_W-2:0], 1'b0};
         if (r >= REM_W'(HISTORY_DEPTH)) begin
            r    = r - REM_W'(HISTORY_DEPTH);
            w[0] = 1'b1;
         end
      end
      rem_next  = r;
      word_next = w;
   end

   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_next;
         word_ff <= word_next;
      end
   end

   assign down_valid = valid_ff;
   assign rem_out    = rem_ff;
   assign word_out   = word_ff;

endmodule

FILE: rtl/ftaq_quality.sv
// ----------------------------------------------------------------------------
// ftaq_quality: band decision and quality factor update
// Compares the average with the target, then lowers or raises the texture,
// effect and resolution factors and registers the response.
// ----------------------------------------------------------------------------
module ftaq_quality (
   input  logic                         clock,
   input  logic                         reset,
   input  ftaq_pkg::cfg_type            cfg,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic [ftaq_pkg::FRAME_W-1:0] avg_in,
   ftaq_rsp_if.source                   rsp_bus
);
   import ftaq_pkg::*;

   logic [FRAME_W+3:0]  avg_x10;
   logic [FRAME_W+3:0]  tgt_x11;
   logic [FRAME_W+3:0]  tgt_x9;
   logic [KIND_W-1:0]   kind_next;

   logic                band_valid_ff;
   logic                band_valid_in;
   logic [FRAME_W-1:0]  band_avg_ff;
   logic [KIND_W-1:0]   band_kind_ff;
   logic                band_load;

   logic                out_ready;
   logic                fire;

   logic [LEVEL_W-1:0]  tex_ff;
   logic [LEVEL_W-1:0]  tex_in;
   logic [LEVEL_W-1:0]  eff_ff;
   logic [LEVEL_W-1:0]  eff_in;
   logic [LEVEL_W-1:0]  res_ff;
   logic [LEVEL_W-1:0]  res_in;
   logic [19:0]         eff_x10;
   logic [19:0]         res_x10;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_payload_type     rsp_payload_ff;
   rsp_payload_type     rsp_payload_in;

   // Band tests in integer form: lower above 110 % of target, raise below 90 %.
   assign avg_x10 = {1'b0, avg_in, 3'b000} + {3'b000, avg_in, 1'b0};
   assign tgt_x11 = (FRAME_W+4)'(cfg.target_frame_ns) * (FRAME_W+4)'(11);
   assign tgt_x9  = (FRAME_W+4)'(cfg.target_frame_ns) * (FRAME_W+4)'(9);

   always_comb begin
      kind_next = KIND_NONE;
      if (cfg.adaptive_enable) begin
         if (avg_x10 > tgt_x11) begin
            kind_next = KIND_LOWER;
         end else if (avg_x10 < tgt_x9) begin
            kind_next = KIND_RAISE;
         end
      end
   end

   assign out_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign up_ready      = !band_valid_ff || out_ready;
   assign band_load     = up_valid && up_ready;
   assign band_valid_in = up_ready ? up_valid : band_valid_ff;
   assign fire          = band_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (band_load) begin
         band_avg_ff  <= avg_in;
         band_kind_ff <= kind_next;
      end
   end

   assign eff_x10 = {1'b0, eff_ff, 3'b000} + {3'b000, eff_ff, 1'b0};
   assign res_x10 = {1'b0, res_ff, 3'b000} + {3'b000, res_ff, 1'b0};

   // Factors move only as a transfer leaves the band stage, one item at a time.
   always_comb begin
      tex_in = tex_ff;
      eff_in = eff_ff;
      res_in = res_ff;
      if (fire) begin
         case (band_kind_ff)
            KIND_LOWER: begin
               if (tex_ff > Q_HALF) begin
                  tex_in = LEVEL_W'(scale_q15(tex_ff, MUL_95));
               end
               if (eff_x10 > EFFECT_FLOOR_X10) begin
                  eff_in = LEVEL_W'(scale_q15(eff_ff, MUL_95));
               end
               if (cfg.dynamic_resolution_enable && (res_x10 > RES_FLOOR_X10)) begin
                  res_in = LEVEL_W'(scale_q15(res_ff, MUL_98));
               end
            end
            KIND_RAISE: begin
               if (tex_ff < Q_ONE) begin
                  tex_in = clamp_q15(scale_q15(tex_ff, MUL_102));
               end
               if (eff_ff < Q_ONE) begin
                  eff_in = clamp_q15(scale_q15(eff_ff, MUL_102));
               end
               if (cfg.dynamic_resolution_enable && (res_ff < Q_ONE)) begin
                  res_in = clamp_q15(scale_q15(res_ff, MUL_101));
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_payload_in.avg_frame_ns     = band_avg_ff;
      rsp_payload_in.texture_level    = tex_in;
      rsp_payload_in.effect_level     = eff_in;
      rsp_payload_in.resolution_level = res_in;
      rsp_payload_in.adjust_kind      = band_kind_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tex_ff        <= Q_ONE;
         eff_ff        <= Q_ONE;
         res_ff        <= Q_ONE;
      end else begin
         band_valid_ff <= band_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tex_ff        <= tex_in;
         eff_ff        <= eff_in;
         res_ff        <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_payload_ff;

endmodule

FILE: rtl/frame_time_adaptive_quality_top.sv
// ----------------------------------------------------------------------------
// frame_time_adaptive_quality_top: adaptive render-quality controller
// A request passes the divider cell chain, then the band stage and the
// response register, before its response transfer. Throughput: one frame
// time per cycle while the receiver is ready; its stalls hold the chain.
// Reset is synchronous and active high: history cells and the running sum
// clear to zero, the quality factors return to 1.0, registers to defaults.
// ----------------------------------------------------------------------------
module frame_time_adaptive_quality_top #(
   parameter int HISTORY_DEPTH = ftaq_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ftaq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ftaq_pkg::CSR_DATA_W-1:0]   csr_wdata,
   ftaq_req_if.sink                          req_bus,
   ftaq_rsp_if.source                        rsp_bus
);
   import ftaq_pkg::*;

   localparam int SUM_W      = FRAME_W + $clog2(HISTORY_DEPTH);
   localparam int REM_W      = rem_width(HISTORY_DEPTH);
   localparam int DIV_W      = div_width(HISTORY_DEPTH);
   localparam int NUM_STAGES = DIV_W / STEP_BITS;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;

   logic                accept;
   logic [FRAME_W-1:0]  hist_data [HISTORY_DEPTH+1];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   logic                div_valid [NUM_STAGES+1];
   logic                div_ready [NUM_STAGES+1];
   logic [REM_W-1:0]    div_rem   [NUM_STAGES+1];
   logic [DIV_W-1:0]    div_word  [NUM_STAGES+1];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET:   cfg_in.target_frame_ns           = csr_wdata[TARGET_W-1:0];
            CSR_ADAPTIVE: cfg_in.adaptive_enable           = csr_wdata[0];
            CSR_DYN_RES:  cfg_in.dynamic_resolution_enable = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_frame_ns           <= TARGET_RESET;
         cfg_ff.adaptive_enable           <= 1'b1;
         cfg_ff.dynamic_resolution_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = req_bus.valid && req_bus.ready;

   // The history is a shift line: the entry leaving the last cell is the one
   // that drops out of the running sum.
   assign hist_data[0] = req_bus.payload.frame_ns;

   for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_hist
      ftaq_hist_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept),
         .data_in  (hist_data[i]),
         .data_out (hist_data[i+1])
      );
   end

   assign sum_in = sum_ff - SUM_W'(hist_data[HISTORY_DEPTH])
                          + SUM_W'(req_bus.payload.frame_ns);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (accept) begin
         sum_ff <= sum_in;
      end
   end

   assign div_valid[0] = req_bus.valid;
   assign req_bus.ready = div_ready[0];
   assign div_rem[0]   = '0;
   assign div_word[0]  = DIV_W'(sum_in);

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_div
      ftaq_div_cell #(
         .HISTORY_DEPTH (HISTORY_DEPTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (div_valid[s]),
         .up_ready   (div_ready[s]),
         .rem_in     (div_rem[s]),
         .word_in    (div_word[s]),
         .down_valid (div_valid[s+1]),
         .down_ready (div_ready[s+1]),
         .rem_out    (div_rem[s+1]),
         .word_out   (div_word[s+1])
      );
   end

   ftaq_quality u_quality (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .up_valid (div_valid[NUM_STAGES]),
      .up_ready (div_ready[NUM_STAGES]),
      .avg_in   (div_word[NUM_STAGES][FRAME_W-1:0]),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: verif/ftaq_quality_checker.sv
// ----------------------------------------------------------------------------
// ftaq_quality_checker: expected-result tracking for the quality controller
// Watches the register port and both channels. Every frame-time transfer is
// run through an independent model of the history ring, the running average
// and the quality factors, and the outcome is queued. Every response transfer
// is compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module ftaq_quality_checker
   import ftaq_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   ftaq_req_if                    req_mon,
   ftaq_rsp_if                    rsp_mon,
   output int                     mismatches,
   output int                     pending,
   output int                     frames_seen,
   output int                     results_checked,
   output int                     lowered,
   output int                     raised,
   output int                     held
);

   localparam int unsigned UNITY = 32768;

   logic [FRAME_W-1:0]  frame_ring [HISTORY_DEPTH];
   int unsigned         ring_slot;
   logic [63:0]         ring_sum;
   logic [LEVEL_W-1:0]  texture_q;
   logic [LEVEL_W-1:0]  effect_q;
   logic [LEVEL_W-1:0]  resolution_q;
   logic [TARGET_W-1:0] target_q;
   logic                adaptive_q;
   logic                dyn_res_q;

   rsp_payload_type     expected_q [$];
   rsp_payload_type     want;
   rsp_payload_type     got;

   function automatic int unsigned percent_of(input int unsigned f, input int unsigned pct);
      return (f * pct) / 100;
   endfunction

   // Records one frame time and returns the response it should produce.
   function automatic rsp_payload_type quality_after_frame(input logic [FRAME_W-1:0] ft);
      rsp_payload_type r;
      logic [63:0]     avg_ns;
      logic [63:0]     target_ns;
      int unsigned     tex;
      int unsigned     eff;
      int unsigned     res;
      ring_sum = ring_sum - frame_ring[ring_slot] + ft;
      frame_ring[ring_slot] = ft;
      ring_slot = (ring_slot + 1 == HISTORY_DEPTH) ? 0 : ring_slot + 1;
      avg_ns    = ring_sum / HISTORY_DEPTH;
      target_ns = {34'd0, target_q};
      tex = texture_q;
      eff = effect_q;
      res = resolution_q;
      r.adjust_kind = KIND_NONE;
      if (adaptive_q) begin
         if (avg_ns * 10 > target_ns * 11) begin
            r.adjust_kind = KIND_LOWER;
            if (tex > UNITY / 2)
               tex = percent_of(tex, 95);
            if (eff * 10 > 3 * UNITY)
               eff = percent_of(eff, 95);
            if (dyn_res_q && res * 10 > 7 * UNITY)
               res = percent_of(res, 98);
         end else if (avg_ns * 10 < target_ns * 9) begin
            r.adjust_kind = KIND_RAISE;
            if (tex < UNITY)
               tex = percent_of(tex, 102);
            if (eff < UNITY)
               eff = percent_of(eff, 102);
            if (dyn_res_q && res < UNITY)
               res = percent_of(res, 101);
            // Growth is clamped at 1.0.
            if (tex > UNITY) tex = UNITY;
            if (eff > UNITY) eff = UNITY;
            if (res > UNITY) res = UNITY;
         end
      end
      texture_q    = LEVEL_W'(tex);
      effect_q     = LEVEL_W'(eff);
      resolution_q = LEVEL_W'(res);
      r.avg_frame_ns     = avg_ns[FRAME_W-1:0];
      r.texture_level    = texture_q;
      r.effect_level     = effect_q;
      r.resolution_level = resolution_q;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_ring[i])
            frame_ring[i] = '0;
         ring_slot       = 0;
         ring_sum        = '0;
         texture_q       = LEVEL_W'(UNITY);
         effect_q        = LEVEL_W'(UNITY);
         resolution_q    = LEVEL_W'(UNITY);
         target_q        = 30'd16666667;
         adaptive_q      = 1'b1;
         dyn_res_q       = 1'b1;
         expected_q.delete();
         mismatches      = 0;
         frames_seen     = 0;
         results_checked = 0;
         lowered         = 0;
         raised          = 0;
         held            = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET:   target_q   = csr_wdata[TARGET_W-1:0];
               CSR_ADAPTIVE: adaptive_q = csr_wdata[0];
               CSR_DYN_RES:  dyn_res_q  = csr_wdata[0];
               default: ;
            endcase
         end

         // Responses are compared before this edge's request is modelled, so a
         // stray response can never be matched against a frame that is just
         // arriving.
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            results_checked++;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with nothing outstanding: avg=%0d tex=%0d eff=%0d res=%0d kind=%0d",
                           results_checked, got.avg_frame_ns, got.texture_level,
                           got.effect_level, got.resolution_level, got.adjust_kind);
            end else begin
               want = expected_q.pop_front();
               if (got.avg_frame_ns !== want.avg_frame_ns ||
                   got.texture_level !== want.texture_level ||
                   got.effect_level !== want.effect_level ||
                   got.resolution_level !== want.resolution_level ||
                   got.adjust_kind !== want.adjust_kind) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d wrong: expected avg=%0d tex=%0d eff=%0d res=%0d kind=%0d",
                              results_checked, want.avg_frame_ns, want.texture_level,
                              want.effect_level, want.resolution_level, want.adjust_kind);
                     $display("   actual avg=%0d tex=%0d eff=%0d res=%0d kind=%0d",
                              got.avg_frame_ns, got.texture_level, got.effect_level,
                              got.resolution_level, got.adjust_kind);
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            want = quality_after_frame(req_mon.payload.frame_ns);
            expected_q.push_back(want);
            frames_seen++;
            case (want.adjust_kind)
               KIND_LOWER: lowered++;
               KIND_RAISE: raised++;
               default:    held++;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: frame-time adaptive quality controller
// Drives frame times over the request channel and random back-pressure on the
// response channel through phases of register settings and idling mixes.
// A directed opening covers the field extremes and both bands; swinging runs
// of slow, near-target and fast frames with random noise follow.
// ----------------------------------------------------------------------------
module testbench;
   import ftaq_pkg::*;

   localparam int LATENCY     = 12;
   // Longest correct stretch without a transfer is the latency plus runs of sender
   // idling and receiver stalls; this limit is far beyond that.
   localparam int QUIET_LIMIT = 5000;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ftaq_req_if req_bus ();
   ftaq_rsp_if rsp_bus ();

   int sender_idle_pct;
   int receiver_stall_pct;
   int quiet_cycles;
   int mismatches;
   int pending;
   int frames_seen;
   int results_checked;
   int lowered;
   int raised;
   int held;

   frame_time_adaptive_quality_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   ftaq_quality_checker quality_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatches      (mismatches),
      .pending         (pending),
      .frames_seen     (frames_seen),
      .results_checked (results_checked),
      .lowered         (lowered),
      .raised          (raised),
      .held            (held)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No transfer for %0d cycles, giving up.", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Leaves valid high after the transfer so that back-to-back frames need no
   // second assignment in the same time step.
   task automatic send_frame(input logic [FRAME_W-1:0] ft);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.payload.frame_ns <= ft;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic start_phase(input logic [TARGET_W-1:0] target, input logic adaptive,
                              input logic dyn_res, input int send_pct, input int stall_pct);
      hold_until_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_TARGET;
      csr_wdata <= target;
      @(posedge clock);
      // Upper bits of the single-bit registers carry junk that must be ignored.
      csr_index <= CSR_ADAPTIVE;
      csr_wdata <= {(CSR_DATA_W-1)'($urandom()), adaptive};
      @(posedge clock);
      csr_index <= CSR_DYN_RES;
      csr_wdata <= {(CSR_DATA_W-1)'($urandom()), dyn_res};
      @(posedge clock);
      csr_we             <= 1'b0;
      sender_idle_pct     = send_pct;
      receiver_stall_pct <= stall_pct;
   endtask

   // Runs of slow, near-target or fast frames drag the average across both
   // bands; a few frames are pure noise or extremes.
   task automatic run_frames(input int count, input longint unsigned base);
      int                 run_left;
      int                 level_pct;
      int                 roll;
      longint unsigned    ns;
      logic [FRAME_W-1:0] ft;
      run_left  = 0;
      level_pct = 100;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 10);
            case ($urandom_range(2))
               0:       level_pct = $urandom_range(85, 10);
               1:       level_pct = $urandom_range(112, 88);
               default: level_pct = $urandom_range(250, 130);
            endcase
         end
         run_left--;
         roll = $urandom_range(99);
         if (roll < 8) begin
            ft = $urandom();
         end else if (roll < 10) begin
            ft = ($urandom_range(1) == 1) ? '1 : '0;
         end else begin
            ns = base * level_pct / 100 + $urandom_range(32'(base / 20));
            ft = (ns > 64'hFFFF_FFFF) ? '1 : ns[FRAME_W-1:0];
         end
         send_frame(ft);
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= CSR_TARGET;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.payload      <= '0;
      receiver_stall_pct   <= 0;
      sender_idle_pct       = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Default registers: zero and tiny frames raise with nothing to raise,
      // then saturated frames push every factor down to its floor.
      send_frame(32'h0000_0000);
      send_frame(32'h0000_0001);
      send_frame(32'h5555_5555);
      send_frame(32'hAAAA_AAAA);
      repeat (26) send_frame(32'hFFFF_FFFF);

      start_phase(30'd16666667, 1'b1, 1'b1, 0, 0);
      run_frames(130, 16666667);
      start_phase(30'd1, 1'b1, 1'b0, 59, 0);
      run_frames(110, 1);
      start_phase(30'd1000000000, 1'b1, 1'b1, 0, 59);
      run_frames(130, 1000000000);
      start_phase(30'd0, 1'b1, 1'b1, 38, 38);
      run_frames(60, 0);
      start_phase(30'h3FFF_FFFF, 1'b0, 1'b1, 59, 59);
      run_frames(100, 30'h3FFF_FFFF);
      start_phase(30'd33333333, 1'b1, 1'b1, 0, 0);
      run_frames(130, 33333333);
      start_phase(30'd8000000, 1'b1, 1'b0, 38, 38);
      run_frames(130, 8000000);
      begin
         logic [TARGET_W-1:0] any_target;
         any_target = TARGET_W'($urandom_range(1000000000, 1));
         start_phase(any_target, 1'b1, 1'b1, 59, 0);
         run_frames(180, any_target);
      end

      hold_until_drained();
      repeat (LATENCY * 4) @(posedge clock);

      $display("Checked %0d responses for %0d frames: %0d lowered, %0d raised, %0d held.",
               results_checked, frames_seen, lowered, raised, held);
      $display("Targets of 0, 1, 1e9 and 2^30-1 with each mode switched on and off, %s",
               "under no idling, sender gaps, receiver stalls and both.");
      if (mismatches == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
